// ===== sv/rgd_pkg.sv =====
package rgd_pkg;

  localparam int MAX_GROUPS = 8;
  localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int TW = GIW + 1;
  localparam logic [31:0] BASE_RESET = 32'd1000000;
  localparam logic [31:0] OVR_MAX = 32'hFFFF_FFFF;
  localparam logic [2:0] REG_BASE = 3'd0;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_ADD    = 2'd1,
    OP_FINISH = 2'd2,
    OP_HALT   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_ACCEPT  = 2'd0,
    K_REJECT  = 2'd1,
    K_RELEASE = 2'd2,
    K_OVERRUN = 2'd3
  } kind_t;

  typedef struct packed {
    op_t         opcode;
    logic [31:0] period_ns;
    logic [2:0]  group_index;
    logic [62:0] now_time;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  group;
    logic [62:0] recent_run;
    logic [62:0] peak_run;
    logic [31:0] overrun_count;
    logic        last;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic        busy;
    logic [63:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

endpackage

// ===== sv/rgd_if.sv =====
interface rgd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] period_ns;
  logic [2:0]  group_index;
  logic [62:0] now_time;
  modport source(output valid, opcode, period_ns, group_index, now_time, input ready);
  modport sink(input valid, opcode, period_ns, group_index, now_time, output ready);
endinterface

interface rgd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  group;
  logic [62:0] recent_run;
  logic [62:0] peak_run;
  logic [31:0] overrun_count;
  logic        last;
  modport source(output valid, kind, group, recent_run, peak_run, overrun_count, last,
                 input ready);
  modport sink(input valid, kind, group, recent_run, peak_run, overrun_count, last,
               output ready);
endinterface

// ===== sv/rgd_front.sv =====
module rgd_front (
  input  logic           clk,
  input  logic           rst_n,
  rgd_in_if.sink         in_ch,
  output logic           q_vld,
  output rgd_pkg::item_t q_item,
  input  logic           q_pop
);
  import rgd_pkg::*;

  item_t       mem_r [2];
  logic        wptr_r, rptr_r;
  logic [1:0]  cnt_r;
  logic        push, pop;
  item_t       in_item;

  always_comb begin
    in_item.opcode      = op_t'(in_ch.opcode);
    in_item.period_ns   = in_ch.period_ns;
    in_item.group_index = in_ch.group_index;
    in_item.now_time    = in_ch.now_time;
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push   = in_ch.valid && in_ch.ready;
  assign q_vld  = (cnt_r != 2'd0);
  assign pop    = q_pop && q_vld;
  assign q_item = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/rgd_div.sv =====
module rgd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rgd_pkg::div_req_t req,
  output rgd_pkg::div_rsp_t rsp
);
  import rgd_pkg::*;

  logic [63:0] dvd_r;
  logic [31:0] dsr_r;
  logic [31:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r, done_r;
  logic [32:0] trial, diff;
  logic        ge;

  // one quotient bit a cycle, restoring
  assign trial = {rem_r, dvd_r[63]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], ge};
      rem_r <= ge ? diff[31:0] : trial[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.busy = busy_r;
  assign rsp.quot = dvd_r;
  assign rsp.rem  = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running divide");

endmodule

// ===== sv/rgd_core.sv =====
module rgd_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_vld,
  input  rgd_pkg::item_t q_item,
  output logic           q_pop,
  input  logic [31:0]    base_ns,
  rgd_out_if.source      out_ch
);
  import rgd_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ADIV   = 9'b000000010,
    S_ASTAT  = 9'b000000100,
    S_EMIT   = 9'b000001000,
    S_TSTART = 9'b000010000,
    S_TDIV   = 9'b000100000,
    S_TPUSH  = 9'b001000000,
    S_FLUSH  = 9'b010000000,
    S_HOLD   = 9'b100000000
  } state_t;

  state_t      state_r;
  logic [31:0] period_r [MAX_GROUPS];
  logic        fin_r    [MAX_GROUPS];
  logic [62:0] rel_r    [MAX_GROUPS];
  logic [62:0] fnt_r    [MAX_GROUPS];
  logic [62:0] rec_r    [MAX_GROUPS];
  logic [62:0] peak_r   [MAX_GROUPS];
  logic [31:0] ovr_r    [MAX_GROUPS];
  logic [TW-1:0]  total_r;
  logic [63:0]    ref_r;
  logic [31:0]    unwind_r;
  logic           halting_r, stopped_r, stop_after_r;
  logic [GIW-1:0] idx_r;
  item_t          cur_r;
  res_t           res_r, pend_r, out_q_r;
  logic           pend_vld_r, out_vld_r;

  div_req_t       dreq;
  div_rsp_t       drsp;
  logic           out_free;
  logic           out_load;
  res_t           out_data;
  logic           found;
  logic [GIW-1:0] fidx;
  logic [TW-1:0]  idx_inc;
  logic [62:0]    rt, new_peak;
  logic [31:0]    unw_dec;
  logic           add_ok;

  rgd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign out_free = !out_vld_r || out_ch.ready;
  assign q_pop    = (state_r == S_IDLE) && q_vld;
  assign idx_inc  = {1'b0, idx_r} + TW'(1);
  assign add_ok   = (base_ns != '0) && (q_item.period_ns >= base_ns);
  assign unw_dec  = (unwind_r != '0) ? unwind_r - 32'd1 : unwind_r;

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = ref_r;
    dreq.divisor  = period_r[idx_r];
    if (state_r == S_IDLE) begin
      dreq.start    = q_vld && (q_item.opcode == OP_ADD) && add_ok;
      dreq.dividend = {32'd0, q_item.period_ns};
      dreq.divisor  = base_ns;
    end else if (state_r == S_TSTART) begin
      dreq.start = 1'b1;
    end
  end

  // lowest group that already has the requested period
  always_comb begin
    found = 1'b0;
    fidx  = '0;
    for (int i = 0; i < MAX_GROUPS; i++) begin
      if (!found && (TW'(i) < total_r) && (period_r[i] == cur_r.period_ns)) begin
        found = 1'b1;
        fidx  = GIW'(i);
      end
    end
  end

  assign rt       = (fnt_r[idx_r] >= rel_r[idx_r]) ? fnt_r[idx_r] - rel_r[idx_r] : '0;
  assign new_peak = (rt > peak_r[idx_r]) ? rt : peak_r[idx_r];

  // item loaded into the output register, flagged last where it ends the input
  always_comb begin
    out_load = 1'b0;
    out_data = pend_r;
    if (state_r == S_EMIT) begin
      out_load      = out_free;
      out_data      = res_r;
      out_data.last = 1'b1;
    end else if (state_r == S_TPUSH) begin
      out_load = out_free && pend_vld_r;
    end else if (state_r == S_FLUSH) begin
      out_load      = out_free && pend_vld_r;
      out_data.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
        out_q_r   <= out_data;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      ref_r        <= '0;
      unwind_r     <= 32'd1;
      halting_r    <= 1'b0;
      stopped_r    <= 1'b0;
      stop_after_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      idx_r        <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        period_r[i] <= '0;
        fin_r[i]    <= 1'b1;
        rel_r[i]    <= '0;
        fnt_r[i]    <= '0;
        rec_r[i]    <= '0;
        peak_r[i]   <= '0;
        ovr_r[i]    <= '0;
      end
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (q_vld) begin
            cur_r <= q_item;
            unique case (q_item.opcode)
              OP_TICK: begin
                if (!stopped_r && base_ns != '0) begin
                  if (halting_r) begin
                    unwind_r <= unw_dec;
                  end
                  stop_after_r <= halting_r && (unw_dec == '0);
                  ref_r        <= ref_r + {32'd0, base_ns};
                  idx_r        <= '0;
                  state_r      <= (total_r == '0) ? S_FLUSH : S_TSTART;
                end
              end
              OP_ADD: begin
                if (!add_ok) begin
                  res_r   <= '{kind: K_REJECT, default: '0};
                  state_r <= S_EMIT;
                end else begin
                  state_r <= S_ADIV;
                end
              end
              OP_FINISH: begin
                if ({1'b0, q_item.group_index} < 4'(total_r)) begin
                  fnt_r[q_item.group_index[GIW-1:0]] <= q_item.now_time;
                  fin_r[q_item.group_index[GIW-1:0]] <= 1'b1;
                end
              end
              OP_HALT: halting_r <= 1'b1;
              default: ;
            endcase
          end
        end
        S_ADIV: begin
          if (drsp.done) begin
            if (drsp.rem != '0) begin
              res_r   <= '{kind: K_REJECT, default: '0};
              state_r <= S_EMIT;
            end else if (found) begin
              idx_r   <= fidx;
              state_r <= S_ASTAT;
            end else if (total_r >= TW'(MAX_GROUPS)) begin
              res_r   <= '{kind: K_REJECT, default: '0};
              state_r <= S_EMIT;
            end else begin
              period_r[total_r[GIW-1:0]] <= cur_r.period_ns;
              fin_r[total_r[GIW-1:0]]    <= 1'b1;
              rel_r[total_r[GIW-1:0]]    <= '0;
              fnt_r[total_r[GIW-1:0]]    <= '0;
              rec_r[total_r[GIW-1:0]]    <= '0;
              peak_r[total_r[GIW-1:0]]   <= '0;
              ovr_r[total_r[GIW-1:0]]    <= '0;
              total_r <= total_r + TW'(1);
              if (drsp.quot[31:0] > unwind_r) begin
                unwind_r <= drsp.quot[31:0];
              end
              res_r   <= '{kind: K_ACCEPT, group: 3'(total_r), default: '0};
              state_r <= S_EMIT;
            end
          end
        end
        S_ASTAT: begin
          res_r <= '{kind: K_ACCEPT, group: 3'(idx_r), recent_run: rec_r[idx_r],
                     peak_run: peak_r[idx_r], overrun_count: ovr_r[idx_r], last: 1'b0};
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_TSTART: state_r <= S_TDIV;
        S_TDIV: begin
          if (drsp.done) begin
            if (drsp.rem == '0) begin
              if (fin_r[idx_r]) begin
                rec_r[idx_r]  <= rt;
                peak_r[idx_r] <= new_peak;
                rel_r[idx_r]  <= cur_r.now_time;
                fin_r[idx_r]  <= 1'b0;
                res_r <= '{kind: K_RELEASE, group: 3'(idx_r), recent_run: rt,
                           peak_run: new_peak, overrun_count: ovr_r[idx_r], last: 1'b0};
              end else begin
                if (ovr_r[idx_r] != OVR_MAX) begin
                  ovr_r[idx_r] <= ovr_r[idx_r] + 32'd1;
                end
                res_r <= '{kind: K_OVERRUN, group: 3'(idx_r), recent_run: rec_r[idx_r],
                           peak_run: peak_r[idx_r],
                           overrun_count: (ovr_r[idx_r] != OVR_MAX) ?
                                          ovr_r[idx_r] + 32'd1 : OVR_MAX,
                           last: 1'b0};
              end
              state_r <= S_TPUSH;
            end else begin
              state_r <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          // advance to the next group or finish the tick
          if (idx_inc < total_r) begin
            idx_r   <= idx_inc[GIW-1:0];
            state_r <= S_TSTART;
          end else begin
            state_r <= S_FLUSH;
          end
        end
        S_TPUSH: begin
          // hold one result back so the final one can be flagged
          if (!pend_vld_r) begin
            pend_r     <= res_r;
            pend_vld_r <= 1'b1;
            state_r    <= S_HOLD;
          end else if (out_free) begin
            pend_r  <= res_r;
            state_r <= S_HOLD;
          end
        end
        S_FLUSH: begin
          if (!pend_vld_r) begin
            stopped_r <= stopped_r | stop_after_r;
            state_r   <= S_IDLE;
          end else if (out_free) begin
            pend_vld_r <= 1'b0;
            stopped_r  <= stopped_r | stop_after_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.kind          = out_q_r.kind;
  assign out_ch.group         = out_q_r.group;
  assign out_ch.recent_run    = out_q_r.recent_run;
  assign out_ch.peak_run      = out_q_r.peak_run;
  assign out_ch.overrun_count = out_q_r.overrun_count;
  assign out_ch.last          = out_q_r.last;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TW'(MAX_GROUPS))
    else $error("group count above table size");

  a_stop_needs_halt: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> halting_r)
    else $error("stopped without halt");

  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == S_TSTART || state_r == S_TDIV || state_r == S_TPUSH ||
                    state_r == S_HOLD || state_r == S_FLUSH))
    else $error("held result outside a tick");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> (state_r == S_ADIV || state_r == S_TDIV))
    else $error("divider running with nobody waiting");

endmodule

// ===== sv/rate_group_dispatcher_unit.sv =====
// finish and halt items complete in the idle state, and a tick with no groups goes straight to
//   the flush; an add below the base period is rejected at once, any other add waits on the divider
// items are handled one at a time; a tick runs a bit-serial 64/32 modulo in the shared divider
//   for every group in use, so a full table takes one divide per group plus result stalls
// reset: synchronous active-low rst_n clears all groups, reference time and halt state
module rate_group_dispatcher_unit (
  input  logic        clk,
  input  logic        rst_n,
  rgd_in_if.sink      in_ch,
  rgd_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rgd_pkg::*;

  logic [31:0] base_r;
  logic        q_vld, q_pop;
  item_t       q_item;
  logic        base_sel;

  assign base_sel   = ({cfg_paddr[2], 2'b00} == REG_BASE);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = base_sel ? base_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && base_sel) begin
      base_r <= cfg_pwdata;
    end
  end

  rgd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_vld  (q_vld),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  rgd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_vld   (q_vld),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .base_ns (base_r),
    .out_ch  (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rgd_pkg::*;

  class frame_sched_sb;
    logic [31:0] base;
    logic [31:0] period[MAX_GROUPS];
    bit          used[MAX_GROUPS];
    bit          finished[MAX_GROUPS];
    logic [63:0] release_at[MAX_GROUPS];
    logic [63:0] finish_at[MAX_GROUPS];
    logic [63:0] recent_rt[MAX_GROUPS];
    logic [63:0] peak_rt[MAX_GROUPS];
    logic [31:0] overrun_cnt[MAX_GROUPS];
    int unsigned total;
    logic [63:0] frame_clock;
    logic [31:0] unwind;
    bit          halting;
    bit          stopped;
    res_t        due_results[$];
    int          mismatches;

    function new();
      base = BASE_RESET;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        period[i] = '0;
        used[i] = 0;
        finished[i] = 1;
        release_at[i] = '0;
        finish_at[i] = '0;
        recent_rt[i] = '0;
        peak_rt[i] = '0;
        overrun_cnt[i] = '0;
      end
      total = 0;
      frame_clock = '0;
      unwind = 32'd1;
      halting = 0;
      stopped = 0;
      mismatches = 0;
    endfunction

    function void push_res(kind_t k, int g, bit stats);
      res_t r;
      r.kind = k;
      r.group = stats ? 3'(g) : 3'd0;
      r.recent_run = stats ? recent_rt[g][62:0] : '0;
      r.peak_run = stats ? peak_rt[g][62:0] : '0;
      r.overrun_count = stats ? overrun_cnt[g] : '0;
      r.last = 1'b0;
      due_results.push_back(r);
    endfunction

    function void add_group(logic [31:0] p);
      int hit;
      hit = -1;
      if (base == 0 || p < base || (p % base) != 0) begin
        push_res(K_REJECT, 0, 0);
        return;
      end
      for (int i = 0; i < total; i++)
        if (hit < 0 && used[i] && period[i] == p) hit = i;
      if (hit >= 0) begin
        push_res(K_ACCEPT, hit, 1);
        return;
      end
      if (total >= MAX_GROUPS) begin
        push_res(K_REJECT, 0, 0);
        return;
      end
      hit = total;
      period[hit] = p;
      used[hit] = 1;
      finished[hit] = 1;
      release_at[hit] = '0;
      finish_at[hit] = '0;
      recent_rt[hit] = '0;
      peak_rt[hit] = '0;
      overrun_cnt[hit] = '0;
      total++;
      if (p / base > unwind) unwind = p / base;
      push_res(K_ACCEPT, hit, 1);
    endfunction

    function void tick(logic [62:0] now);
      bit stop_after;
      logic [63:0] rt;
      stop_after = 0;
      if (stopped || base == 0) return;
      if (halting) begin
        if (unwind > 0) unwind--;
        if (unwind == 0) stop_after = 1;
      end
      frame_clock += {32'd0, base};
      for (int i = 0; i < total; i++) begin
        if (!used[i] || period[i] == 0) continue;
        if (frame_clock % {32'd0, period[i]} != 0) continue;
        if (finished[i]) begin
          rt = '0;
          if (finish_at[i] >= release_at[i]) rt = {1'b0, 63'(finish_at[i] - release_at[i])};
          recent_rt[i] = rt;
          if (rt > peak_rt[i]) peak_rt[i] = rt;
          release_at[i] = {1'b0, now};
          finished[i] = 0;
          push_res(K_RELEASE, i, 1);
        end else begin
          if (overrun_cnt[i] != OVR_MAX) overrun_cnt[i]++;
          push_res(K_OVERRUN, i, 1);
        end
      end
      if (stop_after) stopped = 1;
    endfunction

    function void note_item(item_t it);
      int n0;
      n0 = due_results.size();
      case (it.opcode)
        OP_TICK: tick(it.now_time);
        OP_ADD: add_group(it.period_ns);
        OP_FINISH: begin
          if (it.group_index < total && used[it.group_index]) begin
            finish_at[it.group_index] = {1'b0, it.now_time};
            finished[it.group_index] = 1;
          end
        end
        default: halting = 1;
      endcase
      if (due_results.size() > n0) due_results[due_results.size() - 1].last = 1'b1;
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d group %0d", got.kind, got.group);
        return;
      end
      e = due_results.pop_front();
      if (got.kind !== e.kind || got.group !== e.group ||
          got.recent_run !== e.recent_run || got.peak_run !== e.peak_run ||
          got.overrun_count !== e.overrun_count || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("exp: kind %0d group %0d last_rt %0d max_rt %0d ovr %0d last %0b",
                   e.kind, e.group, e.recent_run, e.peak_run, e.overrun_count, e.last);
          $display("got: kind %0d group %0d last_rt %0d max_rt %0d ovr %0d last %0b",
                   got.kind, got.group, got.recent_run, got.peak_run,
                   got.overrun_count, got.last);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rgd_in_if  in_ch();
  rgd_out_if out_ch();

  rate_group_dispatcher_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #6 clk = ~clk;

  frame_sched_sb sb = new();
  int unsigned items_in = 0;
  int unsigned results_out = 0;
  bit calm = 0;
  logic [62:0] clock_ns = '0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.period_ns = '0;
    in_ch.group_index = '0;
    in_ch.now_time = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    item_t it;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      it.opcode = op_t'(in_ch.opcode);
      it.period_ns = in_ch.period_ns;
      it.group_index = in_ch.group_index;
      it.now_time = in_ch.now_time;
      sb.note_item(it);
      items_in++;
    end
  end

  always @(posedge clk) begin
    res_t r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      r.kind = kind_t'(out_ch.kind);
      r.group = out_ch.group;
      r.recent_run = out_ch.recent_run;
      r.peak_run = out_ch.peak_run;
      r.overrun_count = out_ch.overrun_count;
      r.last = out_ch.last;
      sb.check_result(r);
      results_out++;
    end
  end

  // result side stalls a random number of cycles before each item
  initial begin
    int unsigned seen;
    int gap;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      gap = calm ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      seen = results_out;
      wait (results_out != seen);
    end
  end

  task automatic send_item(op_t op, logic [31:0] p, logic [2:0] g, logic [62:0] t);
    int gap;
    int unsigned seen;
    gap = calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode = op;
    in_ch.period_ns = p;
    in_ch.group_index = g;
    in_ch.now_time = t;
    in_ch.valid = 1'b1;
    seen = items_in;
    wait (items_in != seen);
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.due_results.size() != 0) @(negedge clk);
    // ticks with no due group still walk the table, up to three of them queued
    repeat (2000) @(negedge clk);
  endtask

  task automatic write_base(logic [31:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = 3'(REG_BASE * 4);
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    sb.base = value;
  endtask

  function automatic logic [62:0] pick_time();
    if ($urandom_range(0, 9) == 0) return 63'({$urandom(), $urandom()});
    clock_ns += 63'($urandom_range(0, 3000000));
    return clock_ns;
  endfunction

  task automatic random_items(int count, logic [31:0] base, bit with_halt);
    int sel;
    logic [2:0] g;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      sel = $urandom_range(0, 99);
      if (with_halt && n == count / 2) send_item(OP_HALT, $urandom(), 3'($urandom()), pick_time());
      else if (sel < 40) send_item(OP_TICK, $urandom(), 3'($urandom()), pick_time());
      else if (sel < 72) begin
        g = (sb.total > 0 && $urandom_range(0, 4) != 0) ?
            3'($urandom_range(0, sb.total - 1)) : 3'($urandom());
        send_item(OP_FINISH, $urandom(), g, pick_time());
      end else if (sel < 92)
        send_item(OP_ADD, base * $urandom_range(1, 8), 3'($urandom()), pick_time());
      else if (sel < 97)
        send_item(OP_ADD, $urandom(), 3'($urandom()), 63'({$urandom(), $urandom()}));
      else
        send_item(OP_ADD, base + $urandom_range(1, 2), 3'($urandom()), pick_time());
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: rejects, known periods, release, overrun, clamping, extremes
    send_item(OP_ADD, 32'd0, 3'd0, 63'd0);
    send_item(OP_ADD, 32'd999999, 3'd7, '1);
    send_item(OP_ADD, 32'd1500000, 3'd0, 63'd0);
    send_item(OP_ADD, 32'hFFFFFFFF, 3'd0, 63'd0);
    send_item(OP_ADD, 32'd1000000, 3'd0, 63'd0);
    send_item(OP_ADD, 32'd2000000, 3'd0, 63'd0);
    send_item(OP_ADD, 32'd1000000, 3'd0, 63'd0);
    send_item(OP_TICK, '0, 3'd0, 63'd1000);
    send_item(OP_TICK, '0, 3'd0, 63'd5000);
    send_item(OP_FINISH, '0, 3'd0, '1);
    send_item(OP_FINISH, '0, 3'd1, 63'd10);
    send_item(OP_FINISH, '0, 3'd7, 63'd99);
    send_item(OP_FINISH, '0, 3'd5, 63'd99);
    send_item(OP_TICK, '0, 3'd0, '1);
    send_item(OP_FINISH, '0, 3'd0, 63'd3);
    send_item(OP_FINISH, '0, 3'd0, 63'd7);
    send_item(OP_TICK, '0, 3'd0, 63'd20);
    send_item(OP_TICK, '0, 3'd0, 63'd30);
    send_item(OP_TICK, '0, 3'd0, 63'd40);
    drain();

    write_base(32'd1);
    random_items(80, 32'd1, 0);
    drain();
    write_base(32'hFFFFFFFF);
    send_item(OP_ADD, 32'hFFFFFFFF, 3'd0, pick_time());
    send_item(OP_ADD, 32'hFFFFFFFE, 3'd0, pick_time());
    random_items(60, 32'hFFFFFFFF, 0);
    drain();
    write_base(32'd3);
    random_items(80, 32'd3, 0);
    drain();
    write_base(32'd1);
    send_item(OP_HALT, '0, 3'd0, 63'd0);
    send_item(OP_HALT, '0, 3'd0, 63'd0);
    random_items(90, 32'd1, 0);
    drain();

    if (sb.mismatches == 0 && sb.due_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
